// File: rtl/stpbu_pkg.sv
// ----------------------------------------------------------------------------
// stpbu_pkg
// Shared types and constants of the spanning-tree BPDU update engine.
// ----------------------------------------------------------------------------
package stpbu_pkg;

  localparam int DefMaxPorts = 16;
  localparam int DefIdBits   = 16;

  localparam int IdPortW   = 16;
  localparam int MaskPortW = 16;
  localparam int HopW      = 8;
  localparam int RpW       = 5;
  localparam int PortW     = 4;
  localparam int CountW    = 5;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] CFG_BRIDGE_ID  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_PORT_COUNT = 1'b1;

  localparam logic             CMD_MESSAGE  = 1'b0;
  localparam logic [RpW-1:0]   NO_ROOT_PORT = 5'h1F;
  localparam logic [CountW-1:0] COUNT_RESET = 5'd16;
  localparam logic [HopW-1:0]  HOP_MAX      = 8'hFF;

  typedef struct packed {
    logic                cmd;
    logic [IdPortW-1:0]  root_id;
    logic [IdPortW-1:0]  sender_id;
    logic [HopW-1:0]     hops;
    logic [RpW-1:0]      sender_rp;
    logic [PortW-1:0]    sender_port;
    logic [PortW-1:0]    arrival_port;
  } item_t;

endpackage

// File: rtl/spanning_tree_bpdu_update.sv
// ----------------------------------------------------------------------------
// spanning_tree_bpdu_update
// Spanning-tree port-role engine: compares received configuration words with
// the bridge's view of the root and reports what to send.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word per item: a
//   received configuration message or a hello tick (cmd_i). Each item yields
//   exactly one result word on the output channel (out_valid_o / out_stall_i):
//   send flag, send port mask and the bridge's current root view.
//   The input register takes the word when it is accepted, and the compare
//   and mask update load the result register from it, where out_valid_o
//   rises. Throughput is one item per cycle while out_stall_i does not hold
//   the result register full; the state update is done in the same cycle the
//   item leaves the input register, so the next item sees it immediately.
//   When out_stall_i holds the result register full, the input register
//   holds its word and in_stall_o rises; no item is lost.
//   Reset clears both registers, sets bridge_id to 0, port_count to 16 and
//   the view to "self is root". Writing bridge_id through the configuration
//   port clears the view again; write only while the block is idle.
// ----------------------------------------------------------------------------
module spanning_tree_bpdu_update #(
  parameter int MAX_PORTS = stpbu_pkg::DefMaxPorts,
  parameter int ID_BITS   = stpbu_pkg::DefIdBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [stpbu_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [stpbu_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                cmd_i,
  input  logic [stpbu_pkg::IdPortW-1:0]       msg_root_id_i,
  input  logic [stpbu_pkg::IdPortW-1:0]       msg_sender_id_i,
  input  logic [stpbu_pkg::HopW-1:0]          msg_hops_i,
  input  logic signed [stpbu_pkg::RpW-1:0]    msg_sender_root_port_i,
  input  logic [stpbu_pkg::PortW-1:0]         sender_port_i,
  input  logic [stpbu_pkg::PortW-1:0]         arrival_port_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                send_o,
  output logic [stpbu_pkg::MaskPortW-1:0]     send_mask_o,
  output logic                                is_root_o,
  output logic [stpbu_pkg::IdPortW-1:0]       out_root_id_o,
  output logic [stpbu_pkg::HopW-1:0]          out_hops_o,
  output logic signed [stpbu_pkg::RpW-1:0]    out_root_port_o,
  output logic [stpbu_pkg::MaskPortW-1:0]     designated_ports_o,
  output logic [stpbu_pkg::MaskPortW-1:0]     blocked_ports_o
);
  import stpbu_pkg::*;

  localparam int IdW     = (ID_BITS < IdPortW) ? ID_BITS : IdPortW;
  localparam int PW      = (MAX_PORTS < MaskPortW) ? MAX_PORTS : MaskPortW;
  localparam int PortLim = (MAX_PORTS > 64) ? 64 : MAX_PORTS;
  localparam logic [6:0] PORT_LIM = 7'(PortLim);

  // configuration
  logic [IdW-1:0]    bridge_q;
  logic [CountW-1:0] count_q;

  // view
  logic [IdW-1:0]  root_q, root_d;
  logic [HopW-1:0] hop_q, hop_d;
  logic [RpW-1:0]  rport_q, rport_d;
  logic [IdW-1:0]  up_id_q, up_id_d;
  logic            up_vld_q, up_vld_d;
  logic [PW-1:0]   desg_q, desg_d;
  logic [PW-1:0]   blk_q, blk_d;

  // pipeline
  item_t           s1_q;
  logic            s1_vld_q;
  logic            out_vld_q;
  logic            out_free;
  logic            adv;

  logic            res_send_q;
  logic [PW-1:0]   res_mask_q;
  logic            res_root_q;
  logic [IdW-1:0]  res_root_id_q;
  logic [HopW-1:0] res_hops_q;
  logic [RpW-1:0]  res_rport_q;
  logic [PW-1:0]   res_desg_q;
  logic [PW-1:0]   res_blk_q;

  // compare
  logic [6:0]      n_eff;
  logic [PW-1:0]   ports;
  logic [PW-1:0]   arr_bit;
  logic            connected;
  logic [IdW-1:0]  mroot;
  logic [IdW-1:0]  sender;
  logic [8:0]      sum;
  logic [HopW-1:0] sum_sat;
  logic            forward;
  logic            root_now;
  logic [PW-1:0]   mask;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign adv        = s1_vld_q && out_free;
  assign in_stall_o = s1_vld_q && !out_free;

  always_comb begin
    n_eff = ({2'b00, count_q} > PORT_LIM) ? PORT_LIM : {2'b00, count_q};
    for (int k = 0; k < PW; k++) begin
      ports[k]   = (7'(k) < n_eff);
      arr_bit[k] = (s1_q.arrival_port == PortW'(k));
    end
    connected = ({3'b000, s1_q.arrival_port} < n_eff);
    mroot     = s1_q.root_id[IdW-1:0];
    sender    = s1_q.sender_id[IdW-1:0];
    sum       = {1'b0, s1_q.hops} + 9'd1;
    sum_sat   = sum[8] ? HOP_MAX : sum[7:0];

    root_d   = root_q;
    hop_d    = hop_q;
    rport_d  = rport_q;
    up_id_d  = up_id_q;
    up_vld_d = up_vld_q;
    desg_d   = desg_q;
    blk_d    = blk_q;
    forward  = 1'b0;

    if (s1_q.cmd == CMD_MESSAGE && connected) begin
      if (mroot < root_q || (mroot == root_q && (sum < {1'b0, hop_q} ||
          (sum == {1'b0, hop_q} && up_vld_q && up_id_q > sender)))) begin
        root_d   = mroot;
        hop_d    = sum_sat;
        rport_d  = {1'b0, s1_q.arrival_port};
        up_id_d  = sender;
        up_vld_d = 1'b1;
        blk_d    = blk_q & ~arr_bit;
        forward  = 1'b1;
      end else if (mroot == root_q) begin
        if ((!s1_q.sender_rp[RpW-1] && s1_q.sender_rp[PortW-1:0] == s1_q.sender_port) ||
            s1_q.hops > hop_q || (s1_q.hops == hop_q && bridge_q < sender)) begin
          desg_d  = desg_q | arr_bit;
          blk_d   = blk_q & ~arr_bit;
          forward = 1'b1;
        end else begin
          desg_d = desg_q & ~arr_bit;
          blk_d  = blk_q | arr_bit;
        end
      end
    end

    root_now = (root_d == bridge_q);
    if (root_now) begin
      mask = ports;
    end else if (forward) begin
      mask = ports & ~blk_d;
    end else begin
      mask = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bridge_q <= '0;
      count_q  <= COUNT_RESET;
      root_q   <= '0;
      hop_q    <= '0;
      rport_q  <= NO_ROOT_PORT;
      up_id_q  <= '0;
      up_vld_q <= 1'b0;
      desg_q   <= '0;
      blk_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BRIDGE_ID: begin
          bridge_q <= cfg_wdata_i[IdW-1:0];
          root_q   <= cfg_wdata_i[IdW-1:0];
          hop_q    <= '0;
          rport_q  <= NO_ROOT_PORT;
          up_id_q  <= '0;
          up_vld_q <= 1'b0;
          desg_q   <= '0;
          blk_q    <= '0;
        end
        CFG_PORT_COUNT: begin
          count_q <= cfg_wdata_i[CountW-1:0];
        end
        default: begin
        end
      endcase
    end else if (adv) begin
      root_q   <= root_d;
      hop_q    <= hop_d;
      rport_q  <= rport_d;
      up_id_q  <= up_id_d;
      up_vld_q <= up_vld_d;
      desg_q   <= desg_d;
      blk_q    <= blk_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_vld_q <= in_valid_i;
      end
      if (out_free) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_q.cmd          <= cmd_i;
      s1_q.root_id      <= msg_root_id_i;
      s1_q.sender_id    <= msg_sender_id_i;
      s1_q.hops         <= msg_hops_i;
      s1_q.sender_rp    <= msg_sender_root_port_i;
      s1_q.sender_port  <= sender_port_i;
      s1_q.arrival_port <= arrival_port_i;
    end
    if (adv) begin
      res_send_q    <= |mask;
      res_mask_q    <= mask;
      res_root_q    <= root_now;
      res_root_id_q <= root_d;
      res_hops_q    <= hop_d;
      res_rport_q   <= rport_d;
      res_desg_q    <= desg_d;
      res_blk_q     <= blk_d;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign send_o             = res_send_q;
  assign send_mask_o        = MaskPortW'(res_mask_q);
  assign is_root_o          = res_root_q;
  assign out_root_id_o      = IdPortW'(res_root_id_q);
  assign out_hops_o         = res_hops_q;
  assign out_root_port_o    = res_rport_q;
  assign designated_ports_o = MaskPortW'(res_desg_q);
  assign blocked_ports_o    = MaskPortW'(res_blk_q);

`ifndef SYNTH
  a_roles_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (desg_q & blk_q) == '0)
    else $error("port both designated and blocked");

  a_root_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (root_q == bridge_q) |-> (hop_q == '0 && rport_q == NO_ROOT_PORT && !up_vld_q))
    else $error("root bridge holds a path to another root");

  a_send_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (res_send_q == (res_mask_q != '0)))
    else $error("send flag disagrees with send mask");

  a_root_sends_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && root_now |-> mask == ports)
    else $error("root bridge does not send on all ports");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> s1_vld_q && $stable(s1_q))
    else $error("input register changed while stalled");
`endif

endmodule

// File: verif/spanning_tree_bpdu_update_tb.sv
// ----------------------------------------------------------------------------
// spanning_tree_bpdu_update_tb
// Self-checking testbench for the spanning-tree port-role engine. Drives
// configuration words and hello ticks through the valid/stall channel. A local
// model of the root view, hop distance and port masks predicts every result
// word, and each result is compared field by field against it. Both channels
// idle and stall at random, and the run goes through several bridge ids and
// port counts.
// ----------------------------------------------------------------------------
module spanning_tree_bpdu_update_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stpbu_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 4;
  localparam int PortLimit     = 16;

  typedef struct packed {
    logic                 send;
    logic [MaskPortW-1:0] send_mask;
    logic                 is_root;
    logic [IdPortW-1:0]   root_id;
    logic [HopW-1:0]      hops;
    logic [RpW-1:0]       upstream_port;
    logic [MaskPortW-1:0] desig;
    logic [MaskPortW-1:0] blocked;
  } view_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgDataW-1:0]  cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 cmd_i;
  logic [IdPortW-1:0]   msg_root_id_i;
  logic [IdPortW-1:0]   msg_sender_id_i;
  logic [HopW-1:0]      msg_hops_i;
  logic signed [RpW-1:0] msg_sender_root_port_i;
  logic [PortW-1:0]     sender_port_i;
  logic [PortW-1:0]     arrival_port_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 send_o;
  logic [MaskPortW-1:0] send_mask_o;
  logic                 is_root_o;
  logic [IdPortW-1:0]   out_root_id_o;
  logic [HopW-1:0]      out_hops_o;
  logic signed [RpW-1:0] out_root_port_o;
  logic [MaskPortW-1:0] designated_ports_o;
  logic [MaskPortW-1:0] blocked_ports_o;

  spanning_tree_bpdu_update uut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .cmd_i                  (cmd_i),
    .msg_root_id_i          (msg_root_id_i),
    .msg_sender_id_i        (msg_sender_id_i),
    .msg_hops_i             (msg_hops_i),
    .msg_sender_root_port_i (msg_sender_root_port_i),
    .sender_port_i          (sender_port_i),
    .arrival_port_i         (arrival_port_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .send_o                 (send_o),
    .send_mask_o            (send_mask_o),
    .is_root_o              (is_root_o),
    .out_root_id_o          (out_root_id_o),
    .out_hops_o             (out_hops_o),
    .out_root_port_o        (out_root_port_o),
    .designated_ports_o     (designated_ports_o),
    .blocked_ports_o        (blocked_ports_o)
  );

  // bridge view kept by the testbench
  logic [IdPortW-1:0]   own_id;
  logic [CountW-1:0]    port_cnt;
  logic [IdPortW-1:0]   view_root;
  logic [HopW-1:0]      view_hops;
  logic [RpW-1:0]       view_rport;
  logic [IdPortW-1:0]   up_id;
  logic                 up_known;
  logic [MaskPortW-1:0] desig_mask;
  logic [MaskPortW-1:0] block_mask;

  view_t pending_views[$];
  int    errors;
  int    idle_cycles;
  bit    gaps_on;
  bit    stalls_on;
  int    stall_left;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 1;
    if (r < 90) return $urandom_range(2, 4);
    if (r < 98) return $urandom_range(5, 12);
    return $urandom_range(30, 60);
  endfunction

  function automatic void clear_view();
    view_root  = own_id;
    view_hops  = '0;
    view_rport = NO_ROOT_PORT;
    up_id      = '0;
    up_known   = 1'b0;
    desig_mask = '0;
    block_mask = '0;
  endfunction

  function automatic int live_ports();
    return (port_cnt > PortLimit) ? PortLimit : int'(port_cnt);
  endfunction

  function automatic void adopt_upstream(logic [HopW:0] sum, logic [PortW-1:0] port,
                                         logic [IdPortW-1:0] sender);
    view_hops  = (sum > HOP_MAX) ? HOP_MAX : sum[HopW-1:0];
    view_rport = {1'b0, port};
    up_id      = sender;
    up_known   = 1'b1;
    block_mask[port] = 1'b0;
  endfunction

  function automatic logic weigh_message(item_t it);
    logic [HopW:0] sum;
    sum = {1'b0, it.hops} + 9'd1;
    if (it.root_id < view_root) begin
      view_root = it.root_id;
      adopt_upstream(sum, it.arrival_port, it.sender_id);
      return 1'b1;
    end
    if (it.root_id > view_root) return 1'b0;
    if (sum < {1'b0, view_hops} ||
        (sum == {1'b0, view_hops} && up_known && up_id > it.sender_id)) begin
      adopt_upstream(sum, it.arrival_port, it.sender_id);
      return 1'b1;
    end
    if ((!it.sender_rp[RpW-1] && it.sender_rp[PortW-1:0] == it.sender_port) ||
        it.hops > view_hops || (it.hops == view_hops && own_id < it.sender_id)) begin
      desig_mask[it.arrival_port] = 1'b1;
      block_mask[it.arrival_port] = 1'b0;
      return 1'b1;
    end
    desig_mask[it.arrival_port] = 1'b0;
    block_mask[it.arrival_port] = 1'b1;
    return 1'b0;
  endfunction

  function automatic view_t next_view(item_t it);
    view_t                e;
    int                   n;
    logic [MaskPortW-1:0] ports;
    logic                 fwd;
    logic                 am_root;
    n     = live_ports();
    ports = MaskPortW'((32'd1 << n) - 1);
    fwd   = 1'b0;
    if (it.cmd == CMD_MESSAGE && int'(it.arrival_port) < n) fwd = weigh_message(it);
    am_root = (view_root == own_id);
    if (am_root) e.send_mask = ports;
    else if (fwd) e.send_mask = ports & ~block_mask;
    else e.send_mask = '0;
    e.send          = (e.send_mask != '0);
    e.is_root       = am_root;
    e.root_id       = view_root;
    e.hops          = view_hops;
    e.upstream_port = view_rport;
    e.desig         = desig_mask;
    e.blocked       = block_mask;
    return e;
  endfunction

  task automatic drive_word(item_t it);
    cmd_i                  = it.cmd;
    msg_root_id_i          = it.root_id;
    msg_sender_id_i        = it.sender_id;
    msg_hops_i             = it.hops;
    msg_sender_root_port_i = it.sender_rp;
    sender_port_i          = it.sender_port;
    arrival_port_i         = it.arrival_port;
  endtask

  task automatic send_word(item_t it);
    int gap;
    gap = (gaps_on && $urandom_range(0, 1) == 0) ? pick_len() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    drive_word(it);
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_views.push_back(next_view(it));
  endtask

  task automatic send_msg(logic [15:0] root, logic [15:0] sender, logic [7:0] hops,
                          logic [4:0] rp, logic [3:0] sport, logic [3:0] port);
    item_t it;
    it = '{cmd: ~CMD_MESSAGE, root_id: root, sender_id: sender, hops: hops,
           sender_rp: rp, sender_port: sport, arrival_port: port};
    it.cmd = CMD_MESSAGE;
    send_word(it);
  endtask

  task automatic send_tick(item_t it);
    it.cmd = ~CMD_MESSAGE;
    send_word(it);
  endtask

  // hold the sender until every expected word has arrived
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    drain();
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_BRIDGE_ID) begin
      own_id = data;
      clear_view();
    end else begin
      port_cnt = data[CountW-1:0];
    end
  endtask

  function automatic item_t make_message();
    item_t it;
    int    r;
    int    n;
    n = live_ports();
    it.cmd = ($urandom_range(0, 9) == 0) ? ~CMD_MESSAGE : CMD_MESSAGE;
    r = $urandom_range(0, 9);
    if (r < 5) it.root_id = view_root;
    else if (r < 7) it.root_id = view_root - IdPortW'($urandom_range(1, 4));
    else if (r < 8) it.root_id = view_root + IdPortW'($urandom_range(1, 4));
    else it.root_id = IdPortW'($urandom);
    r = $urandom_range(0, 9);
    if (r < 6) it.hops = view_hops + HopW'($urandom_range(0, 4)) - HopW'(2);
    else if (r < 7) it.hops = HOP_MAX;
    else it.hops = HopW'($urandom);
    r = $urandom_range(0, 9);
    if (r < 4) it.sender_id = up_id + IdPortW'($urandom_range(0, 4)) - IdPortW'(2);
    else if (r < 5) it.sender_id = own_id + IdPortW'($urandom_range(0, 2)) - IdPortW'(1);
    else it.sender_id = IdPortW'($urandom);
    it.sender_port = PortW'($urandom);
    it.sender_rp = ($urandom_range(0, 9) < 4) ? {1'b0, it.sender_port} : RpW'($urandom);
    if (n > 0 && $urandom_range(0, 99) < 85) it.arrival_port = PortW'($urandom_range(0, n - 1));
    else it.arrival_port = PortW'($urandom);
    return it;
  endfunction

  task automatic test_reset_view();
    send_tick('0);
    send_msg(16'h0000, 16'h0005, 8'd0, NO_ROOT_PORT, 4'd0, 4'd3);
  endtask

  task automatic test_role_decisions();
    cfg_write(CFG_BRIDGE_ID, 16'h8000);
    send_msg(16'h8000, 16'h9000, 8'd0, NO_ROOT_PORT, 4'd0, 4'd1);
    send_msg(16'h1000, 16'h2000, 8'd3, 5'd2, 4'd4, 4'd2);
    send_msg(16'h1000, 16'h3000, 8'd1, 5'd7, 4'd4, 4'd6);
    send_msg(16'h1000, 16'h2800, 8'd1, 5'd1, 4'd0, 4'd5);
    send_msg(16'h1000, 16'h2900, 8'd1, 5'd3, 4'd3, 4'd7);
    send_msg(16'h1000, 16'h2900, 8'd2, 5'h10, 4'd0, 4'd8);
    send_msg(16'h1000, 16'h0001, 8'd1, NO_ROOT_PORT, 4'd15, 4'd8);
    send_msg(16'h1000, 16'hFFFF, 8'd5, 5'd0, 4'd1, 4'd9);
    send_msg(16'h1000, 16'hFFFF, 8'd2, 5'd0, 4'd1, 4'd9);
    send_msg(16'h1000, 16'h0000, 8'd2, 5'd15, 4'd14, 4'd9);
    send_msg(16'h2000, 16'h0000, 8'd0, 5'd0, 4'd0, 4'd0);
    send_msg(16'h0000, 16'h0000, 8'hFF, 5'd15, 4'd15, 4'd15);
    send_msg(16'h0000, 16'h0001, 8'd254, 5'd0, 4'd1, 4'd3);
    send_msg(16'h0000, 16'hFFFF, 8'hFF, 5'd15, 4'd15, 4'd4);
    send_tick('1);
    cfg_write(CFG_BRIDGE_ID, 16'hFFFF);
    send_msg(16'hFFFF, 16'h1234, 8'd0, 5'd9, 4'd2, 4'd10);
  endtask

  task automatic test_port_count();
    cfg_write(CFG_PORT_COUNT, 16'd4);
    send_msg(16'h0100, 16'h0200, 8'd1, 5'd0, 4'd0, 4'd9);
    send_msg(16'h0100, 16'h0200, 8'd1, 5'd0, 4'd0, 4'd3);
    cfg_write(CFG_PORT_COUNT, 16'd0);
    send_msg(16'h0010, 16'h0020, 8'd0, 5'd0, 4'd1, 4'd0);
    cfg_write(CFG_BRIDGE_ID, 16'h0000);
    send_tick('0);
    cfg_write(CFG_PORT_COUNT, 16'hFFFF);
    send_tick('0);
    cfg_write(CFG_PORT_COUNT, 16'd1);
    send_msg(16'h0000, 16'h0007, 8'd3, 5'd2, 4'd2, 4'd0);
  endtask

  task automatic test_random_phases();
    logic [CountW-1:0] counts[8];
    logic [IdPortW-1:0] id;
    counts = '{5'd16, 5'd1, 5'd2, 5'd31, 5'd0, 5'd8, 5'd16, 5'd5};
    for (int p = 0; p < 8; p++) begin
      if (p == 0) id = '0;
      else if (p == 1) id = '1;
      else id = IdPortW'($urandom);
      cfg_write(CFG_BRIDGE_ID, id);
      cfg_write(CFG_PORT_COUNT, {(CfgDataW - CountW)'($urandom), counts[p]});
      gaps_on   = (p % 3 != 0);
      stalls_on = (p % 3 != 0);
      for (int i = 0; i < 180; i++) begin
        if (p == 2 && i == 90) drain();
        send_word(make_message());
      end
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i = 1'b0;
      stall_left  = 0;
    end else if (stall_left != 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else if (stalls_on && $urandom_range(0, 3) == 0) begin
      out_stall_i = 1'b1;
      stall_left  = pick_len() - 1;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %h actual %h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    view_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_views.size() == 0) begin
        $error("result word with no expectation waiting");
        errors++;
      end else begin
        want = pending_views.pop_front();
        check_field("send", 16'(want.send), 16'(send_o));
        check_field("send_mask", want.send_mask, send_mask_o);
        check_field("is_root", 16'(want.is_root), 16'(is_root_o));
        check_field("out_root_id", want.root_id, out_root_id_o);
        check_field("out_hops", 16'(want.hops), 16'(out_hops_o));
        check_field("out_root_port", 16'(want.upstream_port),
                    16'(unsigned'(out_root_port_o)));
        check_field("designated_ports", want.desig, designated_ports_o);
        check_field("blocked_ports", want.blocked, blocked_ports_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("spanning_tree_bpdu_update: mismatch");
        $finish;
      end
    end
  end

  initial begin
    errors      = 0;
    idle_cycles = 0;
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_BRIDGE_ID;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    drive_word('0);
    own_id   = '0;
    port_cnt = COUNT_RESET;
    clear_view();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_view();
    test_role_decisions();
    test_port_count();
    test_random_phases();

    drain();
    if (errors == 0) $display("spanning_tree_bpdu_update: match");
    else $display("spanning_tree_bpdu_update: mismatch");
    $finish;
  end

endmodule

// File: spanning_tree_bpdu_update.f
rtl/stpbu_pkg.sv
rtl/spanning_tree_bpdu_update.sv
verif/spanning_tree_bpdu_update_tb.sv
